>>> rtl/hvt_pkg.sv
// Shared types and constants for the homogeneous vertex transform unit.
`default_nettype none
package hvt_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COEF_WIDTH = 32;
  localparam int LANES      = 4;

  // stored coefficient width: wide enough for the loaded value and for 1.0
  localparam int MW = (COEF_WIDTH > FRAC_BITS + 1) ? COEF_WIDTH : FRAC_BITS + 2;
  localparam int PW = MW + 32;   // full product
  localparam int SW = PW + 2;    // exact sum of four products

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_XFORM = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [1:0]        row;
    logic [1:0]        col;
    logic signed [31:0] coef;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] vw;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               saturated;
  } out_t;

  typedef logic [3:0][MW-1:0] mrow_t;
  typedef logic [3:0][31:0]   vec_t;

  typedef struct packed {
    logic s1;   // product stage loads
    logic s2;   // pair-sum stage loads
    logic s3;   // result stage loads
  } lane_en_t;

endpackage
`default_nettype wire

>>> rtl/hvt_lane.sv
// One row lane: four products, a two-level add, floor shift and saturation.
`default_nettype none
module hvt_lane
  import hvt_pkg::*;
(
  input  wire logic         clk,
  input  wire mrow_t        m,
  input  wire vec_t         v,
  input  wire lane_en_t     en,
  output logic [31:0]       res,
  output logic              sat
);

  localparam int F_TOP = FRAC_BITS + 31;

  logic signed [PW-1:0] p_r [4];
  logic signed [SW-1:0] s01_r, s23_r;
  logic signed [SW-1:0] sum;
  logic [SW-F_TOP-1:0]  upper;
  logic                 in_range;
  logic [31:0]          res_r;
  logic                 sat_r;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int c = 0; c < 4; c++) begin
        p_r[c] <= $signed(m[c]) * $signed(v[c]);
      end
    end
    if (en.s2) begin
      s01_r <= SW'(p_r[0]) + SW'(p_r[1]);
      s23_r <= SW'(p_r[2]) + SW'(p_r[3]);
    end
    if (en.s3) begin
      res_r <= in_range ? sum[F_TOP:FRAC_BITS]
                        : (sum[SW-1] ? 32'h8000_0000 : 32'h7fff_ffff);
      sat_r <= ~in_range;
    end
  end

  // arithmetic shift floors; result fits when bits above the 32-bit window agree
  always_comb begin
    sum      = s01_r + s23_r;
    upper    = sum[SW-1:F_TOP];
    in_range = (&upper) | ~(|upper);
  end

  assign res = res_r;
  assign sat = sat_r;

endmodule
`default_nettype wire

>>> rtl/hvt_merge.sv
// Merges the four lane results into one output word and holds it for the sink.
`default_nettype none
module hvt_merge
  import hvt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire vec_t        res,
  input  wire logic [3:0]  sat,
  input  wire logic        res_valid,
  input  wire logic        affine,
  output logic             take,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data
);

  localparam logic [31:0] ONE_Q = 32'(1) << FRAC_BITS;

  logic out_valid_r;
  out_t out_data_r;

  assign take = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= res_valid;
    end
    if (take) begin
      out_data_r.out_x     <= res[0];
      out_data_r.out_y     <= res[1];
      out_data_r.out_z     <= res[2];
      out_data_r.out_w     <= affine ? ONE_Q : res[3];
      // w never counts as clipped in affine mode
      out_data_r.saturated <= sat[0] | sat[1] | sat[2] | (sat[3] & ~affine);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_affine_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && affine |-> out_data_r.out_w == ONE_Q)
    else $error("affine w is not 1.0");
  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("stalled output word dropped");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    take && res_valid |=> out_valid_r)
    else $error("lane result not captured");
`endif

endmodule
`default_nettype wire

>>> rtl/homogeneous_vertex_transform_unit.sv
// Top level: matrix store, input decode, lane pipeline control and output merge.
`default_nettype none
// Multiplies each transform word by a stored 4x4 Q16.16 matrix (reset to identity)
// and returns one saturated result word; a load word writes one coefficient in
// the accepting cycle and returns nothing, so a transform that follows it sees
// the new value. Sustained rate is one word per cycle while the sink does not
// stall: four row lanes of four multipliers each run side by side, and the
// output register holds the result behind four register stages (product,
// pair add, final add with shift and saturation, merge). Stages fill bubbles
// under stall, so in_stall rises only when every stage holds a word and the
// sink stalls. affine_mode must only be written while no transform is in flight.
module homogeneous_vertex_transform_unit
  import hvt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic cfg_data
);

  localparam logic [MW-1:0] ONE_M = MW'(1) << FRAC_BITS;
  localparam logic [31:0]   ONE_V = 32'(1) << FRAC_BITS;

  logic [MW-1:0] mat_r [4][4];
  logic          affine_r;
  logic          v1_r, v2_r, v3_r;
  logic          take;
  lane_en_t      en;
  logic          in_acc, xform_acc;
  vec_t          vin;
  vec_t          lane_res;
  logic [3:0]    lane_sat;
  mrow_t         rows [LANES];

  assign cfg_ready = 1'b1;

  always_comb begin
    en.s3    = ~v3_r | take;
    en.s2    = ~v2_r | en.s3;
    en.s1    = ~v1_r | en.s2;
    in_stall = ~en.s1;
  end

  assign in_acc    = in_valid & ~in_stall;
  assign xform_acc = in_acc & (in_data.kind == KIND_XFORM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      affine_r <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          mat_r[r][c] <= (r == c) ? ONE_M : '0;
        end
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        affine_r <= cfg_data;
      end
      if (en.s1) v1_r <= xform_acc;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (in_acc && in_data.kind == KIND_LOAD) begin
        mat_r[in_data.row][in_data.col] <=
          MW'($signed(in_data.coef[COEF_WIDTH-1:0]));
      end
    end
  end

  always_comb begin
    vin[0] = in_data.vx;
    vin[1] = in_data.vy;
    vin[2] = in_data.vz;
    vin[3] = affine_r ? ONE_V : in_data.vw;
    for (int r = 0; r < LANES; r++) begin
      for (int c = 0; c < 4; c++) begin
        rows[r][c] = mat_r[r][c];
      end
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    hvt_lane u_lane (
      .clk (clk),
      .m   (rows[g]),
      .v   (vin),
      .en  (en),
      .res (lane_res[g]),
      .sat (lane_sat[g])
    );
  end

  hvt_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (lane_res),
    .sat       (lane_sat),
    .res_valid (v3_r),
    .affine    (affine_r),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_load_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.kind == KIND_LOAD |=>
      mat_r[$past(in_data.row)][$past(in_data.col)] ==
        MW'($signed($past(in_data.coef[COEF_WIDTH-1:0]))))
    else $error("coefficient load lost");
  a_xform_enters: assert property (@(posedge clk) disable iff (!rst_n)
    xform_acc |=> v1_r)
    else $error("transform word not in product stage");
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r && v2_r && v3_r && out_valid && out_stall)
    else $error("input stalled with room in pipeline");
`endif

endmodule
`default_nettype wire

>>> tb/sv/hvt_transform_checker.sv
`timescale 1ns / 100ps
// Checker for the vertex transform unit: predicts each transform result and compares it.
module hvt_transform_checker
  import hvt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic cfg_data,
  output int   errors,
  output int   pending
);

  localparam logic signed [65:0] Q_MAX = 66'sd2147483647;
  localparam logic signed [65:0] Q_MIN = -66'sd2147483648;
  localparam logic signed [31:0] ONE   = 32'sd1 <<< FRAC_BITS;

  logic signed [31:0] coef_m [4][4];
  logic               affine_q;
  out_t               xform_results [$];
  out_t               want;

  function automatic out_t predict_xform(input in_t w);
    logic signed [65:0] vec [4];
    logic signed [65:0] m;
    logic signed [65:0] acc;
    logic [31:0]        comp [4];
    logic               clip;
    out_t               res;
    clip   = 1'b0;
    vec[0] = w.vx;
    vec[1] = w.vy;
    vec[2] = w.vz;
    vec[3] = affine_q ? ONE : w.vw;
    for (int r = 0; r < 4; r++) begin
      if (affine_q && r == 3) begin
        comp[r] = ONE;
      end else begin
        // exact 66-bit sum, then floor shift
        acc = '0;
        for (int c = 0; c < 4; c++) begin
          m = coef_m[r][c];
          acc += m * vec[c];
        end
        acc = acc >>> FRAC_BITS;
        if (acc > Q_MAX) begin
          comp[r] = Q_MAX[31:0];
          clip    = 1'b1;
        end else if (acc < Q_MIN) begin
          comp[r] = Q_MIN[31:0];
          clip    = 1'b1;
        end else begin
          comp[r] = acc[31:0];
        end
      end
    end
    res.out_x     = comp[0];
    res.out_y     = comp[1];
    res.out_z     = comp[2];
    res.out_w     = comp[3];
    res.saturated = clip;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %h, got %h", name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          coef_m[r][c] = (r == c) ? ONE : '0;
      affine_q = 1'b0;
      xform_results.delete();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (xform_results.size() == 0) begin
          $error("result word with nothing outstanding: %p", out_data);
          errors++;
        end else begin
          want = xform_results.pop_front();
          check_field("out_x", want.out_x, out_data.out_x);
          check_field("out_y", want.out_y, out_data.out_y);
          check_field("out_z", want.out_z, out_data.out_z);
          check_field("out_w", want.out_w, out_data.out_w);
          check_field("saturated", 32'(want.saturated), 32'(out_data.saturated));
        end
      end
      if (cfg_valid && cfg_ready)
        affine_q = cfg_data;
      if (in_valid && !in_stall) begin
        if (in_data.kind == KIND_XFORM)
          xform_results.push_back(predict_xform(in_data));
        else  // keep the low COEF_WIDTH bits, sign-extended
          coef_m[in_data.row][in_data.col] =
            (in_data.coef <<< (32 - COEF_WIDTH)) >>> (32 - COEF_WIDTH);
      end
    end
    pending = xform_results.size();
  end

endmodule

>>> tb/sv/homogeneous_vertex_transform_unit_test.sv
`timescale 1ns / 100ps
// Testbench top for the vertex transform unit: clock, reset, stimulus, idling and verdict.
module homogeneous_vertex_transform_unit_test
  import hvt_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_ITEMS    = 135;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_data  = 1'b0;
  logic in_stall;
  logic out_valid;
  out_t out_data;
  logic cfg_ready;

  int errors;
  int pending;
  int gap_pct     = 20;
  int stall_pct   = 20;
  int idle_cycles = 0;

  always #4 clk = ~clk;

  homogeneous_vertex_transform_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  hvt_transform_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // sink stalls in bursts
  always begin
    @(posedge clk);
    if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // mostly within +/-8.0; wide_pct percent are full-range or corner values
  function automatic logic [31:0] pick_val(input int unsigned wide_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r >= wide_pct)
      return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
    if (r[0])
      return $urandom;
    case ($urandom_range(0, 4))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0001_0000;
      default: return 32'h0000_0000;
    endcase
  endfunction

  function automatic in_t mk_load(input logic [1:0] row, input logic [1:0] col,
                                  input logic [31:0] coef);
    in_t w;
    w.kind = KIND_LOAD;
    w.row  = row;
    w.col  = col;
    w.coef = coef;
    w.vx   = $urandom;
    w.vy   = $urandom;
    w.vz   = $urandom;
    w.vw   = $urandom;
    return w;
  endfunction

  function automatic in_t mk_xform(input logic [31:0] vx, input logic [31:0] vy,
                                   input logic [31:0] vz, input logic [31:0] vw);
    in_t w;
    w.kind = KIND_XFORM;
    w.row  = 2'($urandom_range(0, 3));
    w.col  = 2'($urandom_range(0, 3));
    w.coef = $urandom;
    w.vx   = vx;
    w.vy   = vy;
    w.vz   = vz;
    w.vw   = vw;
    return w;
  endfunction

  task automatic issue(input in_t w);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold the source until every result is back and the pipe has emptied
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_affine(input logic val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // identity matrix after reset, full-range components pass through
    issue(mk_xform(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF));
    issue(mk_load(2'd0, 2'd0, 32'h7FFF_FFFF));
    issue(mk_xform(32'h7FFF_FFFF, 32'd1, 32'd2, 32'd3));
    issue(mk_xform(32'h8000_0000, 32'd1, 32'd2, 32'd3));
    issue(mk_load(2'd0, 2'd0, 32'h8000_0000));
    issue(mk_xform(32'h8000_0000, 32'd0, 32'd0, 32'd0));
    issue(mk_xform(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0));
    issue(mk_load(2'd0, 2'd0, 32'h0001_0000));
    // negative results round toward minus infinity
    issue(mk_load(2'd3, 2'd3, 32'hFFFF_FFFF));
    issue(mk_xform(32'd0, 32'd0, 32'd0, 32'h0001_0000));
    issue(mk_xform(32'd0, 32'd0, 32'd0, 32'd1));
    issue(mk_load(2'd1, 2'd2, 32'h0000_8000));
    issue(mk_xform(32'd0, 32'd0, 32'd3, 32'd0));
    issue(mk_xform(32'd0, 32'd0, 32'hFFFF_FFFD, 32'd0));
    // four maximal products in one row: sum needs more than 64 bits
    for (int c = 0; c < 4; c++)
      issue(mk_load(2'd2, 2'(c), 32'h7FFF_FFFF));
    issue(mk_xform(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    issue(mk_xform(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));

    // affine: w input ignored, w output fixed at 1.0 and never flagged
    write_affine(1'b1);
    issue(mk_xform(32'd1, 32'd2, 32'd3, 32'h8000_0000));
    for (int c = 0; c < 4; c++)
      issue(mk_load(2'd2, 2'(c), (c == 2) ? 32'h0001_0000 : 32'h0000_0000));
    issue(mk_load(2'd3, 2'd0, 32'h7FFF_FFFF));
    issue(mk_xform(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0));

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = 15 * $urandom_range(0, 3);
        stall_pct = 15 * $urandom_range(0, 3);
      end
      write_affine(ph == 0 ? 1'b0 : ph == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0)
          issue(mk_load(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), pick_val(10)));
        else
          issue(mk_xform(pick_val(30), pick_val(30), pick_val(30), pick_val(30)));
      end
    end

    drain_results();
    @(negedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
